### hw/rtl/source_ip_blacklist_packet_filter_top_assert.svh
// Assertion macros shared by the packet filter checker.
`ifndef SOURCE_IP_BLACKLIST_PACKET_FILTER_TOP_ASSERT_SVH
`define SOURCE_IP_BLACKLIST_PACKET_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SBF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("packet filter assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("packet filter assertion failed");

`endif

### hw/rtl/sbf_pkg.sv
// Types, constants and helper functions of the source blacklist packet filter.
package sbf_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam logic [3:0] PAT_LEN  = 4'd9;
    localparam logic [3:0] PAT_FAIL = 4'd15;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_BLOCKED = 2'd1;
    localparam logic [1:0] REASON_CONTENT = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic        last;
        logic [63:0] arrival_time;
        logic [3:0]  entry_index;
        logic [31:0] entry_ip;
        logic [63:0] entry_id_high;
        logic [63:0] entry_id_low;
        logic        entry_valid;
    } t_in;

    typedef struct packed {
        logic        verdict;
        logic [1:0]  reason_code;
        logic [31:0] source_address;
        logic [63:0] event_id_high;
        logic [63:0] event_id_low;
        logic [63:0] event_time;
        logic [31:0] entry_drops;
        logic [63:0] total_drops;
    } t_out;

    // Summary of one finished frame, produced by the parser.
    typedef struct packed {
        logic        eligible;
        logic        content;
        logic [31:0] src;
    } t_frame;

    // Outcome of one table search.
    typedef struct packed {
        logic        hit;
        logic [63:0] idh;
        logic [63:0] idl;
        logic [31:0] cnt;
    } t_look;

    // Payload pattern "Test Data".
    function automatic logic [7:0] probe_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h54;
            4'd1:    v = 8'h65;
            4'd2:    v = 8'h73;
            4'd3:    v = 8'h74;
            4'd4:    v = 8'h20;
            4'd5:    v = 8'h44;
            4'd6:    v = 8'h61;
            4'd7:    v = 8'h74;
            4'd8:    v = 8'h61;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/sbf_parser.sv
// Byte-serial Ethernet/IPv4/TCP header parser and payload pattern tracker.
module sbf_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output sbf_pkg::t_frame o_sum
);
    import sbf_pkg::*;

    logic [7:0]  r_pos, n_pos;
    logic [3:0]  r_ihl, n_ihl;
    logic [3:0]  r_doff, n_doff;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic        r_et_hi, n_et_hi;
    logic        r_et_ok, n_et_ok;
    logic [3:0]  r_prog, n_prog;

    logic [8:0] pw, tcp, start, len, tcp_f, pl;
    logic [8:0] rel;
    logic       eligible, content;

    always_comb begin
        pw      = {1'b0, r_pos};
        n_pos   = (r_pos == 8'd255) ? r_pos : r_pos + 8'd1;
        n_et_hi = r_et_hi | (r_pos == 8'd12 && i_byte == 8'h08);
        n_et_ok = r_et_ok | (r_pos == 8'd13 && r_et_hi && i_byte == 8'h00);
        n_ihl   = (r_pos == 8'd14) ? i_byte[3:0] : r_ihl;
        n_proto = (r_pos == 8'd23) ? i_byte : r_proto;
        n_src   = (r_pos >= 8'd26 && r_pos <= 8'd29) ? {r_src[23:0], i_byte} : r_src;
        tcp     = 9'd14 + {3'b0, r_ihl, 2'b00};
        start   = tcp + {3'b0, r_doff, 2'b00};
        rel     = pw - start;
        n_doff  = (r_ihl >= 4'd5 && pw == tcp + 9'd12) ? i_byte[7:4] : r_doff;
        n_prog  = r_prog;
        if (r_ihl >= 4'd5 && r_doff >= 4'd5 && pw >= start && pw < start + 9'd9
                && r_prog != PAT_FAIL) begin
            n_prog = (i_byte == probe_byte(rel[3:0])) ? r_prog + 4'd1 : PAT_FAIL;
        end

        // Frame verdict inputs, taken from the state including this byte.
        len      = pw + 9'd1;
        tcp_f    = 9'd14 + {3'b0, n_ihl, 2'b00};
        pl       = tcp_f + {3'b0, n_doff, 2'b00};
        eligible = (len >= 9'd34) && n_et_ok;
        content  = eligible && n_proto == 8'd6 && n_ihl >= 4'd5 && tcp_f + 9'd20 <= len
                   && n_doff >= 4'd5 && pl < len && pl + 9'd9 <= len && n_prog == PAT_LEN;
        o_sum.eligible = eligible;
        o_sum.content  = content;
        o_sum.src      = eligible ? n_src : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_ihl <= '0; r_doff <= '0; r_proto <= '0;
            r_src <= '0; r_et_hi <= 1'b0; r_et_ok <= 1'b0; r_prog <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_pos <= '0; r_ihl <= '0; r_doff <= '0; r_proto <= '0;
                r_src <= '0; r_et_hi <= 1'b0; r_et_ok <= 1'b0; r_prog <= '0;
            end else begin
                r_pos <= n_pos; r_ihl <= n_ihl; r_doff <= n_doff; r_proto <= n_proto;
                r_src <= n_src; r_et_hi <= n_et_hi; r_et_ok <= n_et_ok; r_prog <= n_prog;
            end
        end
    end

endmodule

### hw/rtl/sbf_table.sv
// Blacklist slot memory, per-slot drop counter memory and sequential search engine.
module sbf_table #(
    parameter int ENTRIES = sbf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [3:0]     i_wr_idx,
    input  logic [31:0]    i_wr_ip,
    input  logic [63:0]    i_wr_idh,
    input  logic [63:0]    i_wr_idl,
    input  logic           i_wr_valid,
    input  logic           i_start,
    input  logic           i_search,
    input  logic [31:0]    i_src,
    input  logic           i_ack,
    output logic           o_idle,
    output logic           o_done,
    output sbf_pkg::t_look o_look
);
    import sbf_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CMP, S_CNT, S_DONE} t_state;

    logic [159:0] slot_mem [ENTRIES];
    logic [31:0]  cnt_mem  [ENTRIES];
    logic [159:0] r_slot_q;
    logic [31:0]  r_cnt_q;

    t_state          r_state;
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]   r_idx;
    logic [31:0]     r_src;
    t_look           r_look;

    logic            wr_ok;
    logic [IW-1:0]   wr_addr;
    logic            hit_now;
    logic            cnt_we;
    logic [IW-1:0]   cnt_addr;
    logic [31:0]     cnt_wd;

    always_comb begin
        wr_ok    = i_wr_en && (32'(i_wr_idx) < 32'(ENTRIES));
        wr_addr  = IW'(i_wr_idx);
        hit_now  = r_valid[r_idx] && (r_slot_q[159:128] == r_src);
        cnt_we   = wr_ok || (r_state == S_CNT);
        cnt_addr = wr_ok ? wr_addr : r_idx;
        cnt_wd   = wr_ok ? 32'd0 : r_cnt_q + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            slot_mem[wr_addr] <= {i_wr_ip, i_wr_idh, i_wr_idl};
        end
        if (cnt_we) begin
            cnt_mem[cnt_addr] <= cnt_wd;
        end
        r_slot_q <= slot_mem[r_idx];
        r_cnt_q  <= cnt_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_idx   <= '0;
            r_look  <= '0;
        end else begin
            if (wr_ok) begin
                r_valid[wr_addr] <= i_wr_valid;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_idx  <= '0;
                        r_src  <= i_src;
                        r_look <= '0;
                        r_state <= i_search ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: r_state <= S_CMP;
                S_CMP: begin
                    if (hit_now) begin
                        r_look.hit <= 1'b1;
                        r_look.idh <= r_slot_q[127:64];
                        r_look.idl <= r_slot_q[63:0];
                        r_state    <= S_CNT;
                    end else if (r_idx == LAST_IDX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_CNT: begin
                    r_look.cnt <= r_cnt_q + 32'd1;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_look = r_look;

endmodule

### hw/rtl/source_ip_blacklist_packet_filter_top.sv
// Top level of the source address blacklist packet filter.
//
//   Channel | Signals                         | Payload
//   --------+---------------------------------+-------------------------------
//   input   | i_in_valid / o_in_ready         | i_in  (frame byte or table write)
//   output  | o_out_valid / i_out_ready       | o_out (one verdict per frame)
//
// A table write or a frame byte that is not the last one is taken without a stall.
// After the last byte of a frame the slot memory is searched one entry at a time;
// the input channel stalls during that search and until the verdict has moved
// into the output register. Reset is synchronous and clears the valid bits,
// the global counter and the parser; slot contents need no reset.
// A verdict waiting in the output register does not stop new transfers until
// the next frame's search finishes.
module source_ip_blacklist_packet_filter_top #(
    parameter int TABLE_ENTRIES = sbf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sbf_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sbf_pkg::t_out o_out
);
    import sbf_pkg::*;

    logic   accept, take, frame_end, wr_en;
    t_frame sum;
    t_frame r_sum;
    logic [63:0] r_time;
    logic [63:0] r_total;
    logic   tbl_idle, tbl_done, ack, drop;
    t_look  look;
    t_out   r_out;
    logic   r_out_valid;

    // A transfer is taken whenever the search engine is free.
    assign o_in_ready = tbl_idle;
    assign accept     = i_in_valid && o_in_ready;
    assign wr_en      = accept && (i_in.req_type == REQ_WRITE);
    assign take       = accept && (i_in.req_type == REQ_BYTE);
    assign frame_end  = take && i_in.last;

    sbf_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.data_byte),
        .i_last  (i_in.last),
        .o_sum   (sum)
    );

    sbf_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_idx   (i_in.entry_index),
        .i_wr_ip    (i_in.entry_ip),
        .i_wr_idh   (i_in.entry_id_high),
        .i_wr_idl   (i_in.entry_id_low),
        .i_wr_valid (i_in.entry_valid),
        .i_start    (frame_end),
        .i_search   (sum.eligible),
        .i_src      (sum.src),
        .i_ack      (ack),
        .o_idle     (tbl_idle),
        .o_done     (tbl_done),
        .o_look     (look)
    );

    // The verdict moves into the output register once that register is free.
    assign ack  = tbl_done && (!r_out_valid || i_out_ready);
    assign drop = look.hit || r_sum.content;

    always_ff @(posedge i_clk) begin
        if (frame_end) begin
            r_sum  <= sum;
            r_time <= i_in.arrival_time;
        end
        if (ack) begin
            r_out.verdict        <= drop;
            r_out.reason_code    <= look.hit ? REASON_BLOCKED :
                                    (r_sum.content ? REASON_CONTENT : REASON_NONE);
            r_out.source_address <= r_sum.src;
            r_out.event_id_high  <= look.idh;
            r_out.event_id_low   <= look.idl;
            r_out.event_time     <= r_time;
            r_out.entry_drops    <= look.cnt;
            r_out.total_drops    <= r_total + {63'd0, drop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ack) begin
                r_total     <= r_total + {63'd0, drop};
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hw/rtl/sbf_checker.sv
// Port-level checker for the packet filter and its bind to the top level.
`include "source_ip_blacklist_packet_filter_top_assert.svh"

module sbf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input sbf_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input sbf_pkg::t_out o_out
);
    import sbf_pkg::*;

    `SBF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `SBF_ASSERT_NOW(a_verdict_reason, o_out_valid, o_out.verdict == (o_out.reason_code != REASON_NONE))
    `SBF_ASSERT_NOW(a_no_hit_fields, o_out_valid && o_out.reason_code != REASON_BLOCKED, o_out.entry_drops == 32'd0 && o_out.event_id_high == 64'd0 && o_out.event_id_low == 64'd0)
    `SBF_ASSERT_NEXT(a_search_stall, i_in_valid && o_in_ready && i_in.req_type == REQ_BYTE && i_in.last, !o_in_ready)

endmodule

bind source_ip_blacklist_packet_filter_top sbf_checker u_sbf_checker (.*);
